[hw/rtl/brl_pkg.sv]
// brl_pkg: shared widths, request and command types for the line rasterizer
// no dependencies; used by every module in hw/rtl
`default_nettype none

package brl_pkg;

    localparam int COORD_BITS  = 12;
    localparam int DELTA_BITS  = COORD_BITS + 1;
    localparam int ERR_BITS    = COORD_BITS + 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-1:0] ucoord_t;
    typedef logic        [DELTA_BITS-1:0] delta_t;
    typedef logic        [ERR_BITS-1:0]   err_t;

    typedef struct packed {
        logic   kind;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } in_item_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   last;
    } out_item_t;

    typedef struct packed {
        logic    kind;
        ucoord_t cursor_x;
        ucoord_t cursor_y;
        ucoord_t major_end;
        err_t    error_acc;
        delta_t  error_inc;
        delta_t  error_limit;
        logic    y_major;
        logic    dir_x_neg;
        logic    dir_y_neg;
        logic    active;
    } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/brl_front.sv]
// brl_front: accepts requests, classifies them and works out segment setup
// depends on brl_pkg; feeds brl_queue through a registered command stage
`default_nettype none

module brl_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire brl_pkg::in_item_t s_data,
    output logic                 f_valid,
    input  wire logic            f_ready,
    output brl_pkg::cmd_t        f_cmd
);

    localparam int CW = brl_pkg::COORD_BITS;
    localparam int DW = brl_pkg::DELTA_BITS;
    localparam int EW = brl_pkg::ERR_BITS;

    logic          f_valid_reg, f_valid_next;
    brl_pkg::cmd_t f_cmd_reg, f_cmd_next;

    logic signed [DW-1:0] dx, dy;
    logic [CW-1:0]        adx, ady, amaj, amin;
    logic                 y_major;
    logic                 take;

    assign s_ready = !f_valid_reg || f_ready;
    assign take    = s_valid && s_ready;
    assign f_valid = f_valid_reg;
    assign f_cmd   = f_cmd_reg;

    always_comb begin
        dx = DW'(s_data.end_x) - DW'(s_data.start_x);
        dy = DW'(s_data.end_y) - DW'(s_data.start_y);
        adx = dx[DW-1] ? CW'(-dx) : CW'(dx);
        ady = dy[DW-1] ? CW'(-dy) : CW'(dy);
        y_major = ady > adx;
        amaj = y_major ? ady : adx;
        amin = y_major ? adx : ady;

        f_cmd_next.kind        = s_data.kind;
        f_cmd_next.cursor_x    = s_data.start_x;
        f_cmd_next.cursor_y    = s_data.start_y;
        f_cmd_next.major_end   = y_major ? s_data.end_y : s_data.end_x;
        f_cmd_next.error_acc   = EW'(amaj);
        f_cmd_next.error_inc   = {amin, 1'b0};
        f_cmd_next.error_limit = {amaj, 1'b0};
        f_cmd_next.y_major     = y_major;
        f_cmd_next.dir_x_neg   = dx[DW-1];
        f_cmd_next.dir_y_neg   = dy[DW-1];
        f_cmd_next.active      = amaj != '0;

        if (take) begin
            f_valid_next = 1'b1;
        end else if (f_ready) begin
            f_valid_next = 1'b0;
        end else begin
            f_valid_next = f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            f_cmd_reg <= f_cmd_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/brl_queue.sv]
// brl_queue: short command queue between the front and back parts
// depends on brl_pkg for the command type
`default_nettype none

module brl_queue #(
    parameter int DEPTH = brl_pkg::QUEUE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  wire brl_pkg::cmd_t wr_data,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output brl_pkg::cmd_t      rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [NW-1:0] FULL_CNT = NW'(DEPTH);

    brl_pkg::cmd_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          push, pop;

    assign wr_ready = count_reg != FULL_CNT;
    assign rd_valid = count_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + NW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/brl_back.sv]
// brl_back: holds the segment state, steps the error term, drives the pixel register
// depends on brl_pkg; takes commands from brl_queue
`default_nettype none

module brl_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire brl_pkg::cmd_t q_cmd,
    output logic               m_valid,
    input  wire logic          m_ready,
    output brl_pkg::out_item_t m_data
);

    localparam int CW = brl_pkg::COORD_BITS;
    localparam int EW = brl_pkg::ERR_BITS;

    logic [CW-1:0]         cursor_x_reg, cursor_x_next;
    logic [CW-1:0]         cursor_y_reg, cursor_y_next;
    logic [CW-1:0]         major_end_reg, major_end_next;
    brl_pkg::err_t         error_acc_reg, error_acc_next;
    brl_pkg::delta_t       error_inc_reg, error_inc_next;
    brl_pkg::delta_t       error_limit_reg, error_limit_next;
    logic                  y_major_reg, y_major_next;
    logic                  dir_x_neg_reg, dir_x_neg_next;
    logic                  dir_y_neg_reg, dir_y_neg_next;
    logic                  active_reg, active_next;
    logic                  m_valid_reg, m_valid_next;
    brl_pkg::out_item_t    m_data_reg, m_data_next;

    logic                  out_free, pop, emit;
    brl_pkg::err_t         acc_sum;
    logic                  over;
    logic [CW-1:0]         x_step, y_step, maj_now;

    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = (q_cmd.kind == brl_pkg::KIND_LOAD) || !active_reg || out_free;
    assign pop      = q_valid && q_ready;
    assign emit     = pop && (q_cmd.kind == brl_pkg::KIND_STEP) && active_reg;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        acc_sum = error_acc_reg + EW'(error_inc_reg);
        over    = acc_sum > EW'(error_limit_reg);
        x_step  = dir_x_neg_reg ? cursor_x_reg - CW'(1) : cursor_x_reg + CW'(1);
        y_step  = dir_y_neg_reg ? cursor_y_reg - CW'(1) : cursor_y_reg + CW'(1);
        maj_now = y_major_reg ? y_step : x_step;

        cursor_x_next    = cursor_x_reg;
        cursor_y_next    = cursor_y_reg;
        major_end_next   = major_end_reg;
        error_acc_next   = error_acc_reg;
        error_inc_next   = error_inc_reg;
        error_limit_next = error_limit_reg;
        y_major_next     = y_major_reg;
        dir_x_neg_next   = dir_x_neg_reg;
        dir_y_neg_next   = dir_y_neg_reg;
        active_next      = active_reg;
        m_data_next      = m_data_reg;

        if (pop && (q_cmd.kind == brl_pkg::KIND_LOAD)) begin
            cursor_x_next    = q_cmd.cursor_x;
            cursor_y_next    = q_cmd.cursor_y;
            major_end_next   = q_cmd.major_end;
            error_acc_next   = q_cmd.error_acc;
            error_inc_next   = q_cmd.error_inc;
            error_limit_next = q_cmd.error_limit;
            y_major_next     = q_cmd.y_major;
            dir_x_neg_next   = q_cmd.dir_x_neg;
            dir_y_neg_next   = q_cmd.dir_y_neg;
            active_next      = q_cmd.active;
        end else if (emit) begin
            m_data_next.pixel_x = cursor_x_reg;
            m_data_next.pixel_y = cursor_y_reg;
            m_data_next.last    = maj_now == major_end_reg;
            error_acc_next = over ? acc_sum - EW'(error_limit_reg) : acc_sum;
            if (y_major_reg) begin
                cursor_y_next = y_step;
                cursor_x_next = over ? x_step : cursor_x_reg;
            end else begin
                cursor_x_next = x_step;
                cursor_y_next = over ? y_step : cursor_y_reg;
            end
            if (maj_now == major_end_reg) begin
                active_next = 1'b0;
            end
        end

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cursor_x_reg    <= cursor_x_next;
        cursor_y_reg    <= cursor_y_next;
        major_end_reg   <= major_end_next;
        error_acc_reg   <= error_acc_next;
        error_inc_reg   <= error_inc_next;
        error_limit_reg <= error_limit_next;
        y_major_reg     <= y_major_next;
        dir_x_neg_reg   <= dir_x_neg_next;
        dir_y_neg_reg   <= dir_y_neg_next;
        m_data_reg      <= m_data_next;
    end

endmodule

`default_nettype wire

[hw/rtl/bresenham_line_rasterizer.sv]
// bresenham_line_rasterizer: top level, front setup stage, command queue, stepping back end
// depends on brl_pkg, brl_front, brl_queue and brl_back
//
//   channel | ports                      | moves
//   s_      | s_valid s_ready s_data     | load or step request, brl_pkg::in_item_t
//   m_      | m_valid m_ready m_data     | pixel with last flag, brl_pkg::out_item_t
//
// one request per cycle sustained while m_ready stays high; a step request reaches m_data
// through the front setup register, a queue slot and the pixel register
// the back end does one error add, compare and subtract per cycle, which sets the rate
// a load gives no pixel; a step with no segment pending is consumed without a pixel
// synchronous active-low reset empties the queue and clears the segment; no sweep
// a stalled m_ready backs up the queue, then s_ready falls once the queue and front register are full
`default_nettype none

module bresenham_line_rasterizer #(
    parameter int QUEUE_DEPTH = brl_pkg::QUEUE_DEPTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire brl_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output brl_pkg::out_item_t      m_data
);

    logic          f_valid, f_ready;
    brl_pkg::cmd_t f_cmd;
    logic          q_valid, q_ready;
    brl_pkg::cmd_t q_cmd;

    brl_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .f_valid (f_valid),
        .f_ready (f_ready),
        .f_cmd   (f_cmd)
    );

    brl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_cmd)
    );

    brl_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

[verif/brl_pixel_checker.sv]
// brl_pixel_checker: watches both channels of the line rasterizer, predicts pixels, compares
// depends on brl_pkg; hands its failure count and outstanding pixel count to the testbench top
`default_nettype none

module brl_pixel_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire brl_pkg::in_item_t  s_data,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire brl_pkg::out_item_t m_data,
    output int                      pending_count,
    output int                      fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    brl_pkg::ucoord_t   cur_x      = '0;
    brl_pkg::ucoord_t   cur_y      = '0;
    brl_pkg::ucoord_t   major_stop = '0;
    brl_pkg::err_t      err_acc    = '0;
    brl_pkg::delta_t    err_step   = '0;
    brl_pkg::delta_t    err_wrap   = '0;
    logic               along_y    = 1'b0;
    logic               x_back     = 1'b0;
    logic               y_back     = 1'b0;
    logic               seg_live   = 1'b0;
    int                 mismatches = 0;
    brl_pkg::out_item_t pending_pixels[$];

    assign fail_count = mismatches;

    task automatic advance_raster(input brl_pkg::in_item_t req);
        int                 dx;
        int                 dy;
        int                 adx;
        int                 ady;
        int                 amaj;
        int                 amin;
        brl_pkg::ucoord_t   major_now;
        brl_pkg::out_item_t px;
        if (req.kind == brl_pkg::KIND_LOAD) begin
            dx = int'(req.end_x) - int'(req.start_x);
            dy = int'(req.end_y) - int'(req.start_y);
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            x_back = dx < 0;
            y_back = dy < 0;
            along_y = ady > adx;
            amaj = along_y ? ady : adx;
            amin = along_y ? adx : ady;
            cur_x = req.start_x;
            cur_y = req.start_y;
            major_stop = along_y ? req.end_y : req.end_x;
            err_acc = brl_pkg::err_t'(amaj);
            err_step = brl_pkg::delta_t'(2 * amin);
            err_wrap = brl_pkg::delta_t'(2 * amaj);
            seg_live = amaj != 0;
        end else if (seg_live) begin
            px.pixel_x = cur_x;
            px.pixel_y = cur_y;
            err_acc = err_acc + brl_pkg::err_t'(err_step);
            if (along_y) begin
                cur_y = y_back ? cur_y - 1'b1 : cur_y + 1'b1;
                major_now = cur_y;
            end else begin
                cur_x = x_back ? cur_x - 1'b1 : cur_x + 1'b1;
                major_now = cur_x;
            end
            if (err_acc > brl_pkg::err_t'(err_wrap)) begin
                err_acc = err_acc - brl_pkg::err_t'(err_wrap);
                if (along_y) begin
                    cur_x = x_back ? cur_x - 1'b1 : cur_x + 1'b1;
                end else begin
                    cur_y = y_back ? cur_y - 1'b1 : cur_y + 1'b1;
                end
            end
            px.last = major_now == major_stop;
            if (px.last) begin
                seg_live = 1'b0;
            end
            pending_pixels.push_back(px);
        end
    endtask

    always @(posedge aclk) begin
        brl_pkg::out_item_t want;
        if (!aresetn) begin
            cur_x = '0;
            cur_y = '0;
            major_stop = '0;
            err_acc = '0;
            err_step = '0;
            err_wrap = '0;
            along_y = 1'b0;
            x_back = 1'b0;
            y_back = 1'b0;
            seg_live = 1'b0;
            pending_pixels.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $realtime,
                                 m_data.pixel_x, m_data.pixel_y, m_data.last);
                    end
                    mismatches++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (m_data.pixel_x !== want.pixel_x || m_data.pixel_y !== want.pixel_y ||
                            m_data.last !== want.last) begin
                        if (mismatches < 10) begin
                            $display({"%0t: pixel mismatch: expected x=%0d y=%0d last=%0b,",
                                      " got x=%0d y=%0d last=%0b"},
                                     $realtime, want.pixel_x, want.pixel_y, want.last,
                                     m_data.pixel_x, m_data.pixel_y, m_data.last);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                advance_raster(s_data);
            end
        end
        pending_count <= pending_pixels.size();
    end

endmodule

`default_nettype wire

[verif/bresenham_line_rasterizer_tb.sv]
// bresenham_line_rasterizer_tb: drives load and step requests into the line rasterizer
// depends on brl_pkg, bresenham_line_rasterizer and brl_pixel_checker; gives the verdict
`default_nettype none

module bresenham_line_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     RESET_CYCLES  = 12;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     PHASE_ITEMS   = 400;
    localparam int     COORD_MIN     = -(1 << (brl_pkg::COORD_BITS - 1));
    localparam int     COORD_MAX     = (1 << (brl_pkg::COORD_BITS - 1)) - 1;
    localparam brl_pkg::coord_t C_MIN = brl_pkg::coord_t'(COORD_MIN);
    localparam brl_pkg::coord_t C_MAX = brl_pkg::coord_t'(COORD_MAX);

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    brl_pkg::in_item_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    brl_pkg::out_item_t m_data;
    int                 pending_count;
    int                 fail_count;
    int                 idle_pct    = 0;
    int                 stall_pct   = 0;
    int                 phase_reqs  = 0;

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    bresenham_line_rasterizer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    brl_pixel_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .pending_count (pending_count),
        .fail_count    (fail_count)
    );

    task automatic push_request(input brl_pkg::in_item_t req);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        phase_reqs++;
    endtask

    task automatic send_load(input brl_pkg::coord_t x0, input brl_pkg::coord_t y0,
                             input brl_pkg::coord_t x1, input brl_pkg::coord_t y1);
        brl_pkg::in_item_t req;
        req.kind    = brl_pkg::KIND_LOAD;
        req.start_x = x0;
        req.start_y = y0;
        req.end_x   = x1;
        req.end_y   = y1;
        push_request(req);
    endtask

    // endpoint fields of a step request are junk and must be ignored
    task automatic send_steps(input int n);
        brl_pkg::in_item_t req;
        repeat (n) begin
            req.kind    = brl_pkg::KIND_STEP;
            req.start_x = brl_pkg::coord_t'($urandom);
            req.start_y = brl_pkg::coord_t'($urandom);
            req.end_x   = brl_pkg::coord_t'($urandom);
            req.end_y   = brl_pkg::coord_t'($urandom);
            push_request(req);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic brl_pkg::coord_t pick_coord();
        case ($urandom_range(0, 7))
            0: return C_MIN;
            1: return C_MAX;
            default: return brl_pkg::coord_t'($urandom);
        endcase
    endfunction

    function automatic brl_pkg::coord_t near_coord(input brl_pkg::coord_t base, input int span);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
        if (v < COORD_MIN) begin
            v = COORD_MIN;
        end
        if (v > COORD_MAX) begin
            v = COORD_MAX;
        end
        return brl_pkg::coord_t'(v);
    endfunction

    task automatic run_segment();
        brl_pkg::coord_t x0;
        brl_pkg::coord_t y0;
        brl_pkg::coord_t x1;
        brl_pkg::coord_t y1;
        int              roll;
        int              span;
        int              adx;
        int              ady;
        int              len;
        roll = $urandom_range(0, 99);
        x0 = pick_coord();
        y0 = pick_coord();
        if (roll < 3) begin
            x1 = pick_coord();
            y1 = pick_coord();
        end else begin
            span = (roll < 20) ? 1 : 12;
            x1 = near_coord(x0, span);
            y1 = near_coord(y0, span);
        end
        adx = int'(x1) - int'(x0);
        ady = int'(y1) - int'(y0);
        adx = (adx < 0) ? -adx : adx;
        ady = (ady < 0) ? -ady : ady;
        len = (adx > ady) ? adx : ady;
        send_load(x0, y0, x1, y1);
        if (roll < 3) begin
            send_steps(int'($urandom_range(0, 24)));
        end else if (roll < 90) begin
            send_steps(len + int'($urandom_range(0, 2)));
        end else begin
            // cut short, the next load takes over mid segment
            send_steps(int'($urandom_range(0, len)));
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // steps with nothing loaded
        send_steps(2);
        // full range diagonals, reloaded mid segment
        send_load(C_MIN, C_MIN, C_MAX, C_MAX);
        send_steps(3);
        send_load(C_MAX, C_MAX, C_MIN, C_MIN);
        send_steps(3);
        // degenerate segment
        send_load(12'sd5, -12'sd7, 12'sd5, -12'sd7);
        send_steps(1);
        // steep, heading down at the edge of the window
        send_load(C_MIN, C_MAX, C_MIN, C_MAX - 12'sd3);
        send_steps(4);
        // shallow, heading left
        send_load(C_MAX, C_MIN, C_MAX - 12'sd4, C_MIN + 12'sd1);
        send_steps(5);
        send_load(12'sd0, 12'sd0, 12'sd3, 12'sd3);
        send_steps(3);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 45;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 45;
                end
                default: begin
                    idle_pct  = 12;
                    stall_pct = 12;
                end
            endcase
            phase_reqs = 0;
            while (phase_reqs < PHASE_ITEMS) begin
                run_segment();
            end
            wait_drained();
        end

        stall_pct = 0;
        wait_drained();

        if (fail_count == 0 && pending_count == 0) begin
            $display("** bresenham_line_rasterizer: PASSED **");
        end else begin
            $display("** bresenham_line_rasterizer: FAILED **");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("** bresenham_line_rasterizer: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/brl_pkg.sv
hw/rtl/brl_front.sv
hw/rtl/brl_queue.sv
hw/rtl/brl_back.sv
hw/rtl/bresenham_line_rasterizer.sv
verif/brl_pixel_checker.sv
verif/bresenham_line_rasterizer_tb.sv
